/* hdl/srp_pkg.sv */
// Shared constants and item types of the shelf rectangle packer.
package srp_pkg;

  localparam int MAX_RECTS     = 64;
  localparam int MIN_SIDE_LOG2 = 8;
  localparam int MAX_SIDE_LOG2 = 12;

  localparam int IDX_W  = $clog2(MAX_RECTS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int DIM_W  = 13;
  localparam int POS_W  = 12;
  localparam int LOG_W  = 4;
  localparam int PAD_W  = 8;
  localparam logic [PAD_W-1:0] PAD_RESET = 8'd2;

  typedef struct packed {
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
    logic             rect_last;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] rect_index;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [LOG_W-1:0] side_log2;
    logic             pack_ok;
    logic             result_last;
  } out_item_t;

endpackage

/* hdl/shelf_rect_packer.sv */
// Shelf rectangle packer: load, height rank, shelf placement per atlas side, result drain.
//
// Input channel (in_valid / in_stall / in_item): one rectangle per cycle while
// loading; in_stall is low only in the load state. The item with rect_last set
// ends the set and starts packing; in_stall stays high until the run is done.
// Result channel (out_valid / out_stall / out_item): one result per rectangle in
// descending height order (ties keep load order), or a single failure result
// when nothing fits or more than 64 rectangles arrived. A result register parts
// the two sides, so loading of the next set resumes while the last result waits.
// Configuration: cfg_write_en writes cfg_write_data into the padding register.
// After the last item, ranking runs on a single height compare unit reading one
// memory port; placement then tries each trial side in turn (at most five
// sides), one rectangle at a time, and the drain sends one result at a time
// and waits on any receiver stall.
// On overflow, ranking and placement are skipped and the failure result follows.
// Reset (rst_n low, synchronous) clears the load count, the overflow flag and
// the result valid, sets padding to 2 and returns to the load state.
// While out_stall is high the result register holds its item and the drain
// waits; nothing is lost or repeated.
module shelf_rect_packer (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  srp_pkg::in_item_t        in_item,
  output logic                     out_valid,
  input  logic                     out_stall,
  output srp_pkg::out_item_t       out_item,
  input  logic                     cfg_write_en,
  input  logic [srp_pkg::PAD_W-1:0] cfg_write_data
);

  localparam int IW = srp_pkg::IDX_W;
  localparam int CW = srp_pkg::CNT_W;
  localparam int DW = srp_pkg::DIM_W;
  localparam int PW = srp_pkg::POS_W;
  localparam int LW = srp_pkg::LOG_W;
  localparam int AW = DW + 1;   // padded size
  localparam int SW = DW + 2;   // sums against the side
  localparam int NE = srp_pkg::MAX_RECTS;

  localparam logic [3:0] ST_LOAD    = 4'd0;
  localparam logic [3:0] ST_RK_HI   = 4'd1;
  localparam logic [3:0] ST_RK_HL   = 4'd2;
  localparam logic [3:0] ST_RK_RD   = 4'd3;
  localparam logic [3:0] ST_RK_CMP  = 4'd4;
  localparam logic [3:0] ST_RK_WR   = 4'd5;
  localparam logic [3:0] ST_PK_INIT = 4'd6;
  localparam logic [3:0] ST_PK_ORD  = 4'd7;
  localparam logic [3:0] ST_PK_WH   = 4'd8;
  localparam logic [3:0] ST_PK_ADD  = 4'd9;
  localparam logic [3:0] ST_PK_WRAP = 4'd10;
  localparam logic [3:0] ST_PK_FIT  = 4'd11;
  localparam logic [3:0] ST_OUT_RD  = 4'd12;
  localparam logic [3:0] ST_OUT_LD  = 4'd13;
  localparam logic [3:0] ST_FAIL    = 4'd14;

  localparam logic [LW-1:0] SIDE_MIN = LW'(srp_pkg::MIN_SIDE_LOG2);
  localparam logic [LW-1:0] SIDE_MAX = LW'(srp_pkg::MAX_SIDE_LOG2);

  // memories
  logic [DW-1:0] width_mem  [NE];
  logic [DW-1:0] height_mem [NE];
  logic [IW-1:0] order_mem  [NE];
  logic [PW-1:0] px_mem     [NE];
  logic [PW-1:0] py_mem     [NE];

  logic [DW-1:0] w_rd, h_rd;
  logic [IW-1:0] ord_rd;
  logic [PW-1:0] px_rd, py_rd;

  logic          wh_we, ord_we, pos_we;
  logic [IW-1:0] wh_waddr, wh_raddr;

  // control registers
  logic [3:0]                state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [srp_pkg::PAD_W-1:0] pad_r, pad_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // datapath registers
  logic [CW-1:0]       n_r, n_nxt;
  logic [IW-1:0]       i_r, i_nxt;
  logic [IW-1:0]       j_r, j_nxt;
  logic [IW-1:0]       rank_r, rank_nxt;
  logic [DW-1:0]       hi_r, hi_nxt;
  logic [IW-1:0]       k_r, k_nxt;
  logic [LW-1:0]       side_log_r, side_log_nxt;
  logic [DW-1:0]       pen_r, pen_nxt;
  logic [DW-1:0]       top_r, top_nxt;
  logic [DW-1:0]       shh_r, shh_nxt;
  logic [AW-1:0]       rw_r, rw_nxt;
  logic [AW-1:0]       rh_r, rh_nxt;
  srp_pkg::out_item_t  out_item_r, out_item_nxt;

  logic          in_acc;
  logic          load_ok;
  logic          room;
  logic [CW-1:0] n_m1;
  logic          j_end, k_end;
  logic [SW-1:0] side_w;
  logic [SW-1:0] pen_sum, top_sum;
  logic [DW:0]   top_next_shelf;

  assign in_stall  = (state_r != ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign load_ok   = !out_valid_r || !out_stall;
  assign room      = (count_r < CW'(NE));
  assign n_m1      = n_r - CW'(1);
  assign j_end     = ({1'b0, j_r} == n_m1);
  assign k_end     = ({1'b0, k_r} == n_m1);
  assign side_w    = SW'(1) << side_log_r;
  assign pen_sum   = SW'(pen_r) + SW'(rw_r);
  assign top_sum   = SW'(top_r) + SW'(rh_r);
  assign top_next_shelf = {1'b0, top_r} + {1'b0, shh_r};
  assign wh_waddr  = count_r[IW-1:0];

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    case (state_r)
      ST_RK_HI: wh_raddr = i_r;
      ST_PK_WH: wh_raddr = ord_rd;
      default:  wh_raddr = j_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wh_we) begin
      width_mem[wh_waddr]  <= in_item.rect_width;
      height_mem[wh_waddr] <= in_item.rect_height;
    end
    w_rd <= width_mem[wh_raddr];
    h_rd <= height_mem[wh_raddr];
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      order_mem[rank_r] <= i_r;
    end
    ord_rd <= order_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      px_mem[k_r] <= pen_r[PW-1:0];
      py_mem[k_r] <= top_r[PW-1:0];
    end
    px_rd <= px_mem[k_r];
    py_rd <= py_mem[k_r];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    pad_nxt       = cfg_write_en ? cfg_write_data : pad_r;
    out_valid_nxt = out_valid_r && out_stall;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rank_nxt      = rank_r;
    hi_nxt        = hi_r;
    k_nxt         = k_r;
    side_log_nxt  = side_log_r;
    pen_nxt       = pen_r;
    top_nxt       = top_r;
    shh_nxt       = shh_r;
    rw_nxt        = rw_r;
    rh_nxt        = rh_r;
    out_item_nxt  = out_item_r;
    wh_we         = 1'b0;
    ord_we        = 1'b0;
    pos_we        = 1'b0;

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (room) begin
            wh_we     = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_item.rect_last) begin
            n_nxt     = room ? count_r + CW'(1) : count_r;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            i_nxt     = '0;
            state_nxt = (ovf_r || !room) ? ST_FAIL : ST_RK_HI;
          end
        end
      end

      // rank of item i = items higher, plus equal-height items loaded earlier
      ST_RK_HI: begin
        j_nxt     = '0;
        rank_nxt  = '0;
        state_nxt = ST_RK_HL;
      end

      ST_RK_HL: begin
        hi_nxt    = h_rd;
        state_nxt = ST_RK_RD;
      end

      ST_RK_RD: begin
        state_nxt = ST_RK_CMP;
      end

      ST_RK_CMP: begin
        if ((h_rd > hi_r) || ((h_rd == hi_r) && (j_r < i_r))) begin
          rank_nxt = rank_r + IW'(1);
        end
        if (j_end) begin
          state_nxt = ST_RK_WR;
        end else begin
          j_nxt     = j_r + IW'(1);
          state_nxt = ST_RK_RD;
        end
      end

      ST_RK_WR: begin
        ord_we = 1'b1;
        if ({1'b0, i_r} == n_m1) begin
          side_log_nxt = SIDE_MIN;
          state_nxt    = ST_PK_INIT;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = ST_RK_HI;
        end
      end

      ST_PK_INIT: begin
        pen_nxt   = '0;
        top_nxt   = '0;
        shh_nxt   = '0;
        k_nxt     = '0;
        state_nxt = ST_PK_ORD;
      end

      ST_PK_ORD: begin
        state_nxt = ST_PK_WH;
      end

      ST_PK_WH: begin
        state_nxt = ST_PK_ADD;
      end

      ST_PK_ADD: begin
        rw_nxt    = {1'b0, w_rd} + AW'(pad_r);
        rh_nxt    = {1'b0, h_rd} + AW'(pad_r);
        state_nxt = ST_PK_WRAP;
      end

      // open a new shelf when the row overflows; a rectangle wider than the side tries the next side or fails
      ST_PK_WRAP: begin
        if (SW'(rw_r) > side_w) begin
          if (side_log_r == SIDE_MAX) begin
            state_nxt = ST_FAIL;
          end else begin
            side_log_nxt = side_log_r + LW'(1);
            state_nxt    = ST_PK_INIT;
          end
        end else begin
          if (pen_sum > side_w) begin
            pen_nxt = '0;
            top_nxt = top_next_shelf[DW-1:0];
            shh_nxt = '0;
          end
          state_nxt = ST_PK_FIT;
        end
      end

      ST_PK_FIT: begin
        if (top_sum > side_w) begin
          if (side_log_r == SIDE_MAX) begin
            state_nxt = ST_FAIL;
          end else begin
            side_log_nxt = side_log_r + LW'(1);
            state_nxt    = ST_PK_INIT;
          end
        end else begin
          pos_we  = 1'b1;
          pen_nxt = pen_sum[DW-1:0];
          if (rh_r > AW'(shh_r)) begin
            shh_nxt = rh_r[DW-1:0];
          end
          if (k_end) begin
            k_nxt     = '0;
            state_nxt = ST_OUT_RD;
          end else begin
            k_nxt     = k_r + IW'(1);
            state_nxt = ST_PK_ORD;
          end
        end
      end

      ST_OUT_RD: begin
        state_nxt = ST_OUT_LD;
      end

      // hold until the result register frees up
      ST_OUT_LD: begin
        if (load_ok) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.rect_index  = ord_rd;
          out_item_nxt.pos_x       = px_rd;
          out_item_nxt.pos_y       = py_rd;
          out_item_nxt.side_log2   = side_log_r;
          out_item_nxt.pack_ok     = 1'b1;
          out_item_nxt.result_last = k_end;
          if (k_end) begin
            state_nxt = ST_LOAD;
          end else begin
            k_nxt     = k_r + IW'(1);
            state_nxt = ST_OUT_RD;
          end
        end
      end

      ST_FAIL: begin
        if (load_ok) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt             = '0;
          out_item_nxt.result_last = 1'b1;
          side_log_nxt             = SIDE_MIN;
          state_nxt                = ST_LOAD;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      pad_r       <= srp_pkg::PAD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      pad_r       <= pad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    rank_r     <= rank_nxt;
    hi_r       <= hi_nxt;
    k_r        <= k_nxt;
    side_log_r <= side_log_nxt;
    pen_r      <= pen_nxt;
    top_r      <= top_nxt;
    shh_r      <= shh_nxt;
    rw_r       <= rw_nxt;
    rh_r       <= rh_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

/* sim/tb_shelf_rect_packer.sv */
// Self-checking testbench for the shelf rectangle packer: random sets, shelf placement check.
`timescale 1ns / 100ps

module tb_shelf_rect_packer;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  srp_pkg::in_item_t          in_item = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  srp_pkg::out_item_t         out_item;
  logic                       cfg_write_en = 1'b0;
  logic [srp_pkg::PAD_W-1:0]  cfg_write_data = '0;

  shelf_rect_packer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always #5 clk = ~clk;

  // Packer shadow state
  int unsigned       set_w [srp_pkg::MAX_RECTS];
  int unsigned       set_h [srp_pkg::MAX_RECTS];
  int unsigned       rank [srp_pkg::MAX_RECTS];
  int unsigned       place_x [srp_pkg::MAX_RECTS];
  int unsigned       place_y [srp_pkg::MAX_RECTS];
  int unsigned       set_count = 0;
  bit                set_dropped = 1'b0;
  int unsigned       pad_bits = 32'(srp_pkg::PAD_RESET);

  srp_pkg::in_item_t   rect_queue [$];
  srp_pkg::out_item_t  pending_places [$];

  logic              in_accepted = 1'b0;
  int                send_gap = 0;
  int                stall_left = 0;
  bit                calm = 1'b0;
  int                fault_count = 0;

  // Try one atlas side; fill place_x/place_y in rank order.
  function automatic bit shelf_fit(input int unsigned cnt, input int unsigned side);
    int unsigned k;
    int unsigned rw;
    int unsigned rh;
    int unsigned pen;
    int unsigned top;
    int unsigned shelf;
    pen = 0;
    top = 0;
    shelf = 0;
    for (k = 0; k < cnt; k++) begin
      rw = set_w[rank[k]] + pad_bits;
      rh = set_h[rank[k]] + pad_bits;
      if (rw > side) return 1'b0;
      if (pen + rw > side) begin
        pen = 0;
        top = top + shelf;
        shelf = 0;
      end
      if (top + rh > side) return 1'b0;
      place_x[k] = pen;
      place_y[k] = top;
      pen = pen + rw;
      if (rh > shelf) shelf = rh;
    end
    return 1'b1;
  endfunction

  task automatic load_rect(input srp_pkg::in_item_t it);
    int unsigned n;
    int unsigned i;
    int unsigned j;
    int unsigned key;
    int unsigned lg;
    int unsigned side_lg;
    bit          fit;
    srp_pkg::out_item_t r;
    if (set_count < srp_pkg::MAX_RECTS) begin
      set_w[set_count] = 32'(it.rect_width);
      set_h[set_count] = 32'(it.rect_height);
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!it.rect_last) return;
    n = set_count;
    set_count = 0;
    r = '0;
    r.result_last = 1'b1;
    if (set_dropped) begin
      set_dropped = 1'b0;
      pending_places = {pending_places, r};
      return;
    end
    // Stable rank by descending height
    for (i = 0; i < n; i++) rank[i] = i;
    for (i = 1; i < n; i++) begin
      key = rank[i];
      j = i;
      while (j > 0 && set_h[rank[j-1]] < set_h[key]) begin
        rank[j] = rank[j-1];
        j--;
      end
      rank[j] = key;
    end
    fit = 1'b0;
    side_lg = 0;
    for (lg = srp_pkg::MIN_SIDE_LOG2; lg <= srp_pkg::MAX_SIDE_LOG2 && !fit; lg++) begin
      if (shelf_fit(n, 32'd1 << lg)) begin
        fit = 1'b1;
        side_lg = lg;
      end
    end
    if (!fit) begin
      pending_places = {pending_places, r};
      return;
    end
    for (i = 0; i < n; i++) begin
      r.rect_index  = rank[i][srp_pkg::IDX_W-1:0];
      r.pos_x       = place_x[i][srp_pkg::POS_W-1:0];
      r.pos_y       = place_y[i][srp_pkg::POS_W-1:0];
      r.side_log2   = side_lg[srp_pkg::LOG_W-1:0];
      r.pack_ok     = 1'b1;
      r.result_last = (i + 1 == n);
      pending_places = {pending_places, r};
    end
  endtask

  // Input side: sample acceptance, predict results
  always @(posedge clk) begin
    in_accepted <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) load_rect(in_item);
  end

  // Input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (rect_queue.size() != 0) begin
        in_item <= rect_queue.pop_front();
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) send_gap <= $urandom_range(1, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    srp_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_places.size() == 0) begin
        if (fault_count < 10)
          $display("%0t: unexpected result idx=%0d x=%0d y=%0d lg=%0d ok=%0b last=%0b",
                   $realtime, out_item.rect_index, out_item.pos_x, out_item.pos_y,
                   out_item.side_log2, out_item.pack_ok, out_item.result_last);
        fault_count++;
      end else begin
        want = pending_places.pop_front();
        if (out_item.rect_index !== want.rect_index || out_item.pos_x !== want.pos_x ||
            out_item.pos_y !== want.pos_y || out_item.side_log2 !== want.side_log2 ||
            out_item.pack_ok !== want.pack_ok || out_item.result_last !== want.result_last) begin
          if (fault_count < 10) begin
            $write("%0t: mismatch exp idx=%0d x=%0d y=%0d lg=%0d ok=%0b last=%0b",
                   $realtime, want.rect_index, want.pos_x, want.pos_y, want.side_log2,
                   want.pack_ok, want.result_last);
            $display(" got idx=%0d x=%0d y=%0d lg=%0d ok=%0b last=%0b",
                     out_item.rect_index, out_item.pos_x, out_item.pos_y,
                     out_item.side_log2, out_item.pack_ok, out_item.result_last);
          end
          fault_count++;
        end
      end
    end
  end

  task automatic add_rect(input int unsigned w, input int unsigned h, input bit last);
    srp_pkg::in_item_t it;
    it.rect_width  = w[srp_pkg::DIM_W-1:0];
    it.rect_height = h[srp_pkg::DIM_W-1:0];
    it.rect_last   = last;
    rect_queue = {rect_queue, it};
  endtask

  function automatic int unsigned rand_dim(input bit tiny);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (tiny) return $urandom_range(1, 40);
    if (pick == 0) return ($urandom_range(0, 1) != 0) ? 4096 : 1;
    if (pick <= 2) return $urandom_range(1, 4096);
    if (pick <= 4) return $urandom_range(1, 1024);
    return $urandom_range(1, 60);
  endfunction

  task automatic add_random_set(input int unsigned cnt, input bit tiny);
    int unsigned i;
    for (i = 0; i < cnt; i++) add_rect(rand_dim(tiny), rand_dim(tiny), i + 1 == cnt);
  endtask

  // Hold until every item is sent and every result is back, then let the block settle.
  task automatic wait_idle;
    while (rect_queue.size() != 0 || in_valid || pending_places.size() != 0)
      @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_padding(input int unsigned value);
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value[srp_pkg::PAD_W-1:0];
    pad_bits = value & 8'hFF;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned sent;
    int unsigned pick;
    int unsigned n;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) n = $urandom_range(1, 6);
      else if (pick < 18) n = $urandom_range(7, 20);
      else n = $urandom_range(21, 40);
      add_random_set(n, $urandom_range(0, 3) == 0);
      sent = sent + n;
    end
  endtask

  initial begin
    int unsigned phase_pad [4];
    int unsigned p;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    set_padding(0);
    add_rect(1, 1, 1);
    add_rect(4096, 4096, 1);
    add_rect(4095, 4095, 1);
    // equal heights keep load order
    add_rect(10, 5, 0);
    add_rect(20, 9, 0);
    add_rect(30, 5, 0);
    add_rect(40, 9, 1);
    // second rectangle overruns the row
    add_rect(100, 20, 0);
    add_rect(200, 10, 1);
    add_rect(300, 1, 1);
    // nothing fits
    add_rect(4096, 4096, 0);
    add_rect(4096, 4096, 1);
    // fill the largest atlas exactly
    add_rect(2048, 2048, 0);
    add_rect(2048, 2048, 0);
    add_rect(2048, 2048, 0);
    add_rect(2048, 2048, 1);
    wait_idle();

    set_padding(255);
    add_rect(1, 1, 1);
    add_rect(2, 1, 1);
    // padded width above every side
    add_rect(4096, 1, 1);
    wait_idle();

    phase_pad[0] = 2;
    phase_pad[1] = $urandom_range(1, 254);
    phase_pad[2] = 0;
    phase_pad[3] = 255;
    for (p = 0; p < 4; p++) begin
      set_padding(phase_pad[p]);
      if (p == 3) calm = 1'b1;
      if (p == 0) begin
        add_random_set(srp_pkg::MAX_RECTS, 1'b1);
        add_random_set($urandom_range(srp_pkg::MAX_RECTS + 1, srp_pkg::MAX_RECTS + 6), 1'b1);
      end
      run_random(45);
      wait_idle();
    end

    repeat (50) @(posedge clk);
    if (fault_count == 0 && pending_places.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
